// ===== rtl/ipc_pkg.sv =====
`default_nettype none

package ipc_pkg;

  localparam int unsigned SUM_W     = 7;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  // Input fields from the lowest bit up: target_sum, largest_part.
  typedef struct packed {
    logic [SUM_W-1:0] largest_part;
    logic [SUM_W-1:0] target_sum;
  } in_item_t;

endpackage

`default_nettype wire

// ===== rtl/ipc_count_ram.sv =====
`default_nettype none

module ipc_count_ram #(
  parameter int unsigned DEPTH  = 65,
  parameter int unsigned ADDR_W = 7
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [ipc_pkg::COUNT_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]           raddr_a,
  input  wire logic [ADDR_W-1:0]           raddr_b,
  output logic      [ipc_pkg::COUNT_W-1:0] rdata_a,
  output logic      [ipc_pkg::COUNT_W-1:0] rdata_b
);

  logic [ipc_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/integer_partition_counter_top.sv =====
`default_nettype none

// Counts the partitions of target_sum into parts no larger than largest_part,
// saturating at 0xFFFFFFFF (m_tuser high when the count sits at that value).
// One item at a time: the block sets entry 0 of a scratch RAM to one and
// clears entries 1..sum, one per cycle, then runs the partition recurrence at
// one table cell per cycle through a two-read, one-write RAM with a
// read-add-write pipeline that forwards the in-flight write. A zero limit
// (count 0), a zero sum (count 1) or a sum above MAX_SUM (answered with count 0
// and m_tuser high) skips the table and goes straight to the result.
module integer_partition_counter_top #(
  parameter int unsigned MAX_SUM = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // target_sum [6:0], largest_part [13:7], zero [15:14]
  input  wire logic [ipc_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // way_count [31:0]
  output logic      [ipc_pkg::M_TDATA_W-1:0] m_tdata,
  // saturated [0]
  output logic      [0:0]                    m_tuser
);

  localparam int unsigned DEPTH  = MAX_SUM + 1;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                      state;
  ipc_pkg::in_item_t           in_item;
  logic [ipc_pkg::SUM_W-1:0]   sum_q;
  logic [ipc_pkg::SUM_W-1:0]   lim_q;
  logic [ipc_pkg::SUM_W-1:0]   i_q;
  logic [ipc_pkg::SUM_W-1:0]   j_q;
  logic                        p1_vld;
  logic                        p1_last;
  logic [ADDR_W-1:0]           p1_addr;
  logic                        fwd_a;
  logic                        fwd_b;
  logic [ipc_pkg::COUNT_W-1:0] last_sum;
  logic [ipc_pkg::COUNT_W-1:0] res_count;
  logic                        res_sat;

  logic [ADDR_W-1:0]           rd_addr_a;
  logic [ADDR_W-1:0]           rd_addr_b;
  logic [ipc_pkg::COUNT_W-1:0] rdata_a;
  logic [ipc_pkg::COUNT_W-1:0] rdata_b;
  logic [ipc_pkg::COUNT_W-1:0] op_a;
  logic [ipc_pkg::COUNT_W-1:0] op_b;
  logic [ipc_pkg::COUNT_W:0]   add_full;
  logic [ipc_pkg::COUNT_W-1:0] sat_sum;
  logic                        we;
  logic [ADDR_W-1:0]           waddr;
  logic [ipc_pkg::COUNT_W-1:0] wdata;

  assign in_item  = ipc_pkg::in_item_t'(s_tdata[2*ipc_pkg::SUM_W-1:0]);
  assign s_tready = (state == ST_IDLE);

  assign rd_addr_a = ADDR_W'(i_q);
  assign rd_addr_b = ADDR_W'(i_q - j_q);

  assign op_a     = fwd_a ? last_sum : rdata_a;
  assign op_b     = fwd_b ? last_sum : rdata_b;
  assign add_full = {1'b0, op_a} + {1'b0, op_b};
  assign sat_sum  = add_full[ipc_pkg::COUNT_W] ? ipc_pkg::COUNT_TOP
                                                : add_full[ipc_pkg::COUNT_W-1:0];

  always_comb begin
    if (state == ST_INIT) begin
      we    = 1'b1;
      waddr = ADDR_W'(i_q);
      wdata = (i_q == '0) ? ipc_pkg::COUNT_W'(1) : '0;
    end else begin
      we    = p1_vld;
      waddr = p1_addr;
      wdata = sat_sum;
    end
  end

  ipc_count_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      p1_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      p1_vld <= (state == ST_RUN);
      if (p1_vld) begin
        last_sum <= sat_sum;
      end
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (in_item.largest_part == '0) begin
              res_count <= '0;
              res_sat   <= 1'b0;
              state     <= ST_DONE;
            end else if (int'(in_item.target_sum) > MAX_SUM) begin
              res_count <= '0;
              res_sat   <= 1'b1;
              state     <= ST_DONE;
            end else if (in_item.target_sum == '0) begin
              res_count <= ipc_pkg::COUNT_W'(1);
              res_sat   <= 1'b0;
              state     <= ST_DONE;
            end else begin
              sum_q <= in_item.target_sum;
              lim_q <= (in_item.largest_part > in_item.target_sum) ?
                       in_item.target_sum : in_item.largest_part;
              i_q   <= '0;
              state <= ST_INIT;
            end
          end
        end

        ST_INIT: begin
          if (i_q == sum_q) begin
            i_q   <= ipc_pkg::SUM_W'(1);
            j_q   <= ipc_pkg::SUM_W'(1);
            state <= ST_RUN;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end

        ST_RUN: begin
          p1_addr <= rd_addr_a;
          p1_last <= (i_q == sum_q) && (j_q == lim_q);
          fwd_a   <= p1_vld && (p1_addr == rd_addr_a);
          fwd_b   <= p1_vld && (p1_addr == rd_addr_b);
          if (i_q == sum_q) begin
            if (j_q == lim_q) begin
              state <= ST_DRAIN;
            end else begin
              j_q <= j_q + 1'b1;
              i_q <= j_q + 1'b1;
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
        end

        ST_DRAIN: begin
          res_count <= sat_sum;
          res_sat   <= (sat_sum == ipc_pkg::COUNT_TOP);
          state     <= ST_DONE;
        end

        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_count;
            m_tuser  <= res_sat;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_flag_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == ipc_pkg::COUNT_TOP || m_tdata == '0))
    else $error("saturation flag with a count that is neither top nor zero");

  a_run_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (j_q <= i_q && i_q <= sum_q && j_q <= lim_q))
    else $error("table walk out of bounds");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (p1_vld && p1_last && p1_addr == ADDR_W'(sum_q)))
    else $error("result taken from a cell other than the final one");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr <= ADDR_W'(sum_q)))
    else $error("scratch write beyond the target sum");

endmodule

`default_nettype wire
